FILE: rtl/dmsh_pkg.sv
`default_nettype none
package dmsh_pkg;

    localparam logic [29:0] MOD_P = 30'd1000000007;
    localparam logic [29:0] MOD_Q = 30'd1000000009;
    localparam logic [29:0] HASH_BASE = 30'd233;

    // multiplier bits walked for the base and for a full operand
    localparam int BASE_STEPS = 8;
    localparam int FULL_STEPS = 30;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_ZERO,
        K_CLEAR,
        K_RANGE,
        K_FULL,
        K_APPEND,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  digit;
        logic [11:0] left;
        logic [11:0] right;
        logic [12:0] span;
    } t_job;

    // one step of msb-first interleaved modular multiplication
    function automatic logic [29:0] mod_step(input logic [29:0] acc, input logic [29:0] a,
                                             input logic bitv, input logic [29:0] m);
        logic [31:0] t;
        logic [31:0] m1;
        logic [31:0] m2;
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, acc, 1'b0} + (bitv ? {2'b00, a} : 32'd0);
        if (t >= m2) begin
            t = t - m2;
        end else if (t >= m1) begin
            t = t - m1;
        end
        return t[29:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dmsh_ram.sv
`default_nettype none
module dmsh_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/dmsh_front.sv
`default_nettype none
module dmsh_front #(
    parameter int MAX_LEN = 4096,
    parameter int LW      = $clog2(MAX_LEN + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_full,
    input  wire logic [1:0]    i_cmd,
    input  wire logic [7:0]    i_char_byte,
    input  wire logic [11:0]   i_left_index,
    input  wire logic [11:0]   i_right_index,
    output logic               o_push,
    output dmsh_pkg::t_job     o_job
);
    import dmsh_pkg::*;

    localparam int CW = (LW > 12) ? LW : 12;

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;

    assign o_push = i_start && !i_full;

    always_comb begin
        n_len        = r_len;
        o_job.kind   = K_ZERO;
        o_job.digit  = {1'b0, i_char_byte} + 9'd1;
        o_job.left   = i_left_index;
        o_job.right  = i_right_index;
        o_job.span   = {1'b0, i_right_index - i_left_index} + 13'd1;
        case (i_cmd)
            CMD_APPEND: begin
                if (r_len == LW'(MAX_LEN)) begin
                    o_job.kind = K_FULL;
                end else begin
                    o_job.kind = K_APPEND;
                    n_len      = r_len + 1'b1;
                end
            end
            CMD_QUERY: begin
                if (i_left_index > i_right_index) begin
                    o_job.kind = K_ZERO;
                end else if (CW'(i_right_index) >= CW'(r_len)) begin
                    o_job.kind = K_RANGE;
                end else begin
                    o_job.kind = K_QUERY;
                end
            end
            CMD_CLEAR: begin
                o_job.kind = K_CLEAR;
                n_len      = '0;
            end
            default: begin
                o_job.kind = K_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (o_push) begin
            r_len <= n_len;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dmsh_fifo.sv
`default_nettype none
module dmsh_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dmsh_pkg::t_job i_job,
    input  wire logic           i_pop,
    output dmsh_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);
    import dmsh_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dmsh_back.sv
`default_nettype none
module dmsh_back #(
    parameter int LW  = 13,
    parameter int PAW = 12,
    parameter int WAW = 13
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dmsh_pkg::t_job i_job,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_pre_we,
    output logic [PAW-1:0]      o_pre_waddr,
    output logic [59:0]         o_pre_wdata,
    output logic [PAW-1:0]      o_pre_raddr,
    input  wire logic [59:0]    i_pre_rdata,
    output logic                o_pow_we,
    output logic [WAW-1:0]      o_pow_waddr,
    output logic [59:0]         o_pow_wdata,
    output logic [WAW-1:0]      o_pow_raddr,
    input  wire logic [59:0]    i_pow_rdata,
    output logic                o_valid,
    output logic [29:0]         o_hash_p,
    output logic [29:0]         o_hash_q,
    output logic [12:0]         o_span_length,
    output logic [1:0]          o_status
);
    import dmsh_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_QA, S_QB, S_MUL, S_FIN} t_state;

    t_state        r_state;
    t_job          r_job;
    logic [LW-1:0] r_len;
    logic [29:0]   r_last_p, r_last_q, r_pow_p, r_pow_q;
    logic [29:0]   r_hr_p, r_hr_q;
    logic [29:0]   r_a [4];
    logic [29:0]   r_b [4];
    logic [29:0]   r_acc [4];
    logic [29:0]   n_acc [4];
    logic [4:0]    r_cnt;
    logic          r_valid;
    logic [29:0]   r_hp, r_hq;
    logic [12:0]   r_span;
    logic [1:0]    r_status;
    logic [30:0]   app_p, app_q, qry_p, qry_q;
    logic [29:0]   fin_p, fin_q;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign o_pre_raddr = (r_state == S_QA) ? PAW'(r_job.right) :
                         (i_job.left == 12'd0) ? PAW'(i_job.right) :
                         PAW'(i_job.left - 12'd1);
    assign o_pow_raddr = WAW'(i_job.span);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_acc[i] = mod_step(r_acc[i], r_a[i], r_b[i][r_cnt], i[0] ? MOD_Q : MOD_P);
        end
    end

    // append adds the digit, query subtracts the scaled left prefix
    always_comb begin
        app_p = {1'b0, r_acc[0]} + {22'd0, r_job.digit};
        app_q = {1'b0, r_acc[1]} + {22'd0, r_job.digit};
        if (app_p >= {1'b0, MOD_P}) app_p = app_p - {1'b0, MOD_P};
        if (app_q >= {1'b0, MOD_Q}) app_q = app_q - {1'b0, MOD_Q};
        qry_p = {1'b0, r_hr_p} - {1'b0, r_acc[0]};
        qry_q = {1'b0, r_hr_q} - {1'b0, r_acc[1]};
        if (r_hr_p < r_acc[0]) qry_p = qry_p + {1'b0, MOD_P};
        if (r_hr_q < r_acc[1]) qry_q = qry_q + {1'b0, MOD_Q};
        fin_p = (r_job.kind == K_APPEND) ? app_p[29:0] : qry_p[29:0];
        fin_q = (r_job.kind == K_APPEND) ? app_q[29:0] : qry_q[29:0];
    end

    assign o_pre_we    = (r_state == S_FIN) && (r_job.kind == K_APPEND);
    assign o_pre_waddr = PAW'(r_len);
    assign o_pre_wdata = {fin_p, fin_q};
    assign o_pow_we    = o_pre_we;
    assign o_pow_waddr = WAW'(r_len + 1'b1);
    assign o_pow_wdata = {r_acc[2], r_acc[3]};

    assign o_valid       = r_valid;
    assign o_hash_p      = r_hp;
    assign o_hash_q      = r_hq;
    assign o_span_length = r_span;
    assign o_status      = r_status;

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (r_state == S_MUL) begin
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= n_acc[i];
            end
            r_cnt <= r_cnt - 5'd1;
        end
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_job    <= i_job;
                    r_hp     <= '0;
                    r_hq     <= '0;
                    r_span   <= '0;
                    r_status <= ST_OK;
                    case (i_job.kind)
                        K_APPEND: begin
                            r_a[0] <= (r_len == '0) ? 30'd0 : r_last_p;
                            r_a[1] <= (r_len == '0) ? 30'd0 : r_last_q;
                            r_a[2] <= (r_len == '0) ? 30'd1 : r_pow_p;
                            r_a[3] <= (r_len == '0) ? 30'd1 : r_pow_q;
                            for (int i = 0; i < 4; i++) begin
                                r_b[i]   <= HASH_BASE;
                                r_acc[i] <= '0;
                            end
                            r_cnt   <= 5'(BASE_STEPS - 1);
                            r_state <= S_MUL;
                        end
                        K_QUERY: begin
                            r_state <= S_QA;
                        end
                        K_RANGE: begin
                            r_status <= ST_RANGE;
                            r_valid  <= 1'b1;
                        end
                        K_FULL: begin
                            r_span   <= 13'(r_len);
                            r_status <= ST_FULL;
                            r_valid  <= 1'b1;
                        end
                        K_CLEAR: begin
                            r_len   <= '0;
                            r_valid <= 1'b1;
                        end
                        default: begin
                            r_valid <= 1'b1;
                        end
                    endcase
                end
            end
            S_QA: begin
                if (r_job.left == 12'd0) begin
                    r_hp    <= i_pre_rdata[59:30];
                    r_hq    <= i_pre_rdata[29:0];
                    r_span  <= r_job.span;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end else begin
                    r_a[0] <= i_pre_rdata[59:30];
                    r_a[1] <= i_pre_rdata[29:0];
                    r_b[0] <= i_pow_rdata[59:30];
                    r_b[1] <= i_pow_rdata[29:0];
                    r_a[2] <= '0;
                    r_a[3] <= '0;
                    r_b[2] <= '0;
                    r_b[3] <= '0;
                    for (int i = 0; i < 4; i++) begin
                        r_acc[i] <= '0;
                    end
                    r_cnt   <= 5'(FULL_STEPS - 1);
                    r_state <= S_QB;
                end
            end
            S_QB: begin
                r_hr_p  <= i_pre_rdata[59:30];
                r_hr_q  <= i_pre_rdata[29:0];
                r_state <= S_MUL;
            end
            S_MUL: begin
                if (r_cnt == 5'd0) begin
                    r_state <= S_FIN;
                end
            end
            S_FIN: begin
                r_hp    <= fin_p;
                r_hq    <= fin_q;
                r_valid <= 1'b1;
                r_state <= S_IDLE;
                if (r_job.kind == K_APPEND) begin
                    r_last_p <= fin_p;
                    r_last_q <= fin_q;
                    r_pow_p  <= r_acc[2];
                    r_pow_q  <= r_acc[3];
                    r_len    <= r_len + 1'b1;
                    r_span   <= 13'(r_len + 1'b1);
                end else begin
                    r_span <= r_job.span;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/double_mod_substring_hash_core.sv
`default_nettype none
// Polynomial hash of a growing byte string under moduli 1000000007 and
// 1000000009, base 233. An item is taken while busy is low; a two-entry queue
// holds items until the execution side frees up. Results come on o_valid for
// one cycle and cannot be held off. Work per item in the execution side:
// clear, out-of-range, empty-span, full-store and unused codes finish at the
// pop; an append pops, walks the 8 base bits on the shared bit-serial modular
// multiplier and finishes; a query with left index zero pops and reads its
// prefix; any other query does two memory reads, walks 30 multiplier bits and
// finishes. The multiplier runs four modular lanes side by side, one multiplier bit per cycle.
module double_mod_substring_hash_core #(
    parameter int MAX_LEN = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic [11:0] i_left_index,
    input  wire logic [11:0] i_right_index,
    output logic             o_valid,
    output logic [29:0]      o_hash_p,
    output logic [29:0]      o_hash_q,
    output logic [12:0]      o_span_length,
    output logic [1:0]       o_status
);
    import dmsh_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int PAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WAW = $clog2(MAX_LEN + 1);

    t_job           push_job;
    t_job           head_job;
    logic           push, pop, q_empty, q_full;
    logic           pre_we, pow_we;
    logic [PAW-1:0] pre_waddr, pre_raddr;
    logic [WAW-1:0] pow_waddr, pow_raddr;
    logic [59:0]    pre_wdata, pre_rdata, pow_wdata, pow_rdata;

    assign busy = q_full;

    dmsh_front #(.MAX_LEN(MAX_LEN), .LW(LW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_full(q_full),
        .i_cmd(i_cmd), .i_char_byte(i_char_byte), .i_left_index(i_left_index),
        .i_right_index(i_right_index), .o_push(push), .o_job(push_job)
    );

    dmsh_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .i_pop(pop), .o_job(head_job), .o_empty(q_empty), .o_full(q_full)
    );

    dmsh_ram #(.WIDTH(60), .DEPTH(MAX_LEN), .AW(PAW)) u_prefix_ram (
        .i_clk(i_clk), .i_we(pre_we), .i_waddr(pre_waddr), .i_wdata(pre_wdata),
        .i_raddr(pre_raddr), .o_rdata(pre_rdata)
    );

    dmsh_ram #(.WIDTH(60), .DEPTH(MAX_LEN + 1), .AW(WAW)) u_power_ram (
        .i_clk(i_clk), .i_we(pow_we), .i_waddr(pow_waddr), .i_wdata(pow_wdata),
        .i_raddr(pow_raddr), .o_rdata(pow_rdata)
    );

    dmsh_back #(.LW(LW), .PAW(PAW), .WAW(WAW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(head_job), .i_empty(q_empty),
        .o_pop(pop),
        .o_pre_we(pre_we), .o_pre_waddr(pre_waddr), .o_pre_wdata(pre_wdata),
        .o_pre_raddr(pre_raddr), .i_pre_rdata(pre_rdata),
        .o_pow_we(pow_we), .o_pow_waddr(pow_waddr), .o_pow_wdata(pow_wdata),
        .o_pow_raddr(pow_raddr), .i_pow_rdata(pow_rdata),
        .o_valid(o_valid), .o_hash_p(o_hash_p), .o_hash_q(o_hash_q),
        .o_span_length(o_span_length), .o_status(o_status)
    );

`ifndef SYNTHESIS
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_hash_p == 30'd0 && o_hash_q == 30'd0))
        else $error("flagged result carries a nonzero hash");

    a_hash_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hash_p < MOD_P && o_hash_q < MOD_Q))
        else $error("hash not reduced below its modulus");

    a_item_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !q_empty)
        else $error("accepted item missing from queue");
`endif

endmodule
`default_nettype wire
